[design/slot_allocator_free_stack_assert.svh]
// assertion macros for the slot allocator checks
// used by slot_allocator_free_stack; expects a clock and an active-low reset as arguments
`ifndef SLOT_ALLOCATOR_FREE_STACK_ASSERT_SVH
`define SLOT_ALLOCATOR_FREE_STACK_ASSERT_SVH

// condition that holds at every edge out of reset
`define SAFS_ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("slot allocator invariant violated");

// same-cycle implication
`define SAFS_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("slot allocator implication violated");

// next-cycle implication
`define SAFS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("slot allocator next-cycle check violated");

`endif

[design/safs_pkg.sv]
// shared types and codes for the slot allocator
// no dependencies
package safs_pkg;

    localparam int unsigned IDX_W    = 10;
    localparam int unsigned STATUS_W = 3;

    typedef enum logic
    {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } op_t;

    typedef enum logic [STATUS_W-1:0]
    {
        ST_OK         = 3'd0,
        ST_FULL       = 3'd1,
        ST_BAD_INDEX  = 3'd2,
        ST_NOT_IN_USE = 3'd3,
        ST_FAULT      = 3'd4
    } status_t;

endpackage

[design/slot_allocator_free_stack.sv]
// Slot allocator: free stack of released slots backed by a bump counter.
// Each memory is read once and written at most once per cycle.
// Throughput: one transaction per cycle unless m_tready stalls the result register.
// Reset clears counters and valid flags only; no clearing pass, in-use marks at or
// beyond the bump counter are treated as unused, so the block is ready right after reset.
// Depends on safs_pkg and slot_allocator_free_stack_assert.svh.
`include "slot_allocator_free_stack_assert.svh"

module slot_allocator_free_stack
    import safs_pkg::*;
#(
    parameter int unsigned SLOT_COUNT = 1024
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [9:0] slot_index, [15:10] zero
    input  logic        s_tuser,   // [0] operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [9:0] granted_slot, [15:10] zero
    output logic [2:0]  m_tuser    // [2:0] status
);

    localparam int unsigned AW    = $clog2(SLOT_COUNT);
    localparam int unsigned CW    = $clog2(SLOT_COUNT + 1);
    localparam int unsigned CMP_W = (CW > IDX_W) ? CW : IDX_W;

    // input register
    logic             b_valid_reg;
    logic             b_op_reg;
    logic [IDX_W-1:0] b_idx_reg;

    // result register
    logic             m_valid_reg;
    status_t          m_status_reg;
    logic [IDX_W-1:0] m_slot_reg;

    // counters
    logic [CW-1:0] depth_reg;
    logic [CW-1:0] depth_next;
    logic [CW-1:0] nun_reg;
    logic [CW-1:0] nun_next;

    // in-use marks, one read and one write port
    logic          inuse_mem [SLOT_COUNT];
    logic          inuse_rd_reg;
    logic          inuse_fwd_hit_reg;
    logic          inuse_fwd_val_reg;
    logic          inuse_we;
    logic [AW-1:0] inuse_waddr;
    logic          inuse_wdata;
    logic [AW-1:0] inuse_raddr;
    logic          inuse_q;

    // released stack, top kept in the registered read data
    logic [AW-1:0] stk_mem [SLOT_COUNT];
    logic [AW-1:0] stk_rd_reg;
    logic          stk_byp_hit_reg;
    logic [AW-1:0] stk_byp_val_reg;
    logic          stk_we;
    logic [AW-1:0] stk_waddr;
    logic [AW-1:0] stk_wdata;
    logic [CW-1:0] stk_raddr_full;
    logic [AW-1:0] stk_raddr;
    logic [AW-1:0] stk_top;

    logic             s_fire;
    logic             b_fire;
    logic             stack_empty;
    logic             pool_full;
    logic [IDX_W-1:0] raddr_idx;
    logic [CMP_W-1:0] raddr_ext;
    logic [CMP_W-1:0] idx_ext;
    logic [CMP_W-1:0] nun_ext;
    logic [AW-1:0]    alloc_slot;
    logic [CMP_W-1:0] alloc_slot_ext;
    status_t          status_next;
    logic [IDX_W-1:0] granted_next;

    assign b_fire   = b_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !b_valid_reg || b_fire;
    assign s_fire   = s_tvalid && s_tready;

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = {{(16 - IDX_W){1'b0}}, m_slot_reg};

    // in-use read follows the item that sits in the input register next cycle
    assign raddr_idx   = s_fire ? s_tdata[IDX_W-1:0] : b_idx_reg;
    assign raddr_ext   = CMP_W'(raddr_idx);
    assign inuse_raddr = raddr_ext[AW-1:0];
    assign inuse_q     = inuse_fwd_hit_reg ? inuse_fwd_val_reg : inuse_rd_reg;

    assign stk_top        = stk_byp_hit_reg ? stk_byp_val_reg : stk_rd_reg;
    assign stk_raddr_full = depth_next - CW'(1);
    assign stk_raddr      = stk_raddr_full[AW-1:0];

    assign idx_ext     = CMP_W'(b_idx_reg);
    assign nun_ext     = CMP_W'(nun_reg);
    assign stack_empty = (depth_reg == '0);
    assign pool_full   = stack_empty && (nun_reg == CW'(SLOT_COUNT));
    assign alloc_slot_ext = CMP_W'(alloc_slot);

    always_comb
    begin
        depth_next   = depth_reg;
        nun_next     = nun_reg;
        inuse_we     = 1'b0;
        inuse_waddr  = idx_ext[AW-1:0];
        inuse_wdata  = 1'b0;
        stk_we       = 1'b0;
        stk_waddr    = depth_reg[AW-1:0];
        stk_wdata    = idx_ext[AW-1:0];
        alloc_slot   = stk_top;
        status_next  = ST_OK;
        granted_next = '0;

        if (b_op_reg == OP_ALLOC)
        begin
            if (!stack_empty)
            begin
                alloc_slot = stk_top;
                depth_next = depth_reg - CW'(1);
            end
            else
            begin
                alloc_slot = nun_reg[AW-1:0];
                if (!pool_full)
                begin
                    nun_next = nun_reg + CW'(1);
                end
            end
            if (pool_full)
            begin
                status_next = ST_FULL;
            end
            else
            begin
                inuse_we     = b_fire;
                inuse_waddr  = alloc_slot;
                inuse_wdata  = 1'b1;
                granted_next = alloc_slot_ext[IDX_W-1:0];
            end
        end
        else
        begin
            if (idx_ext >= nun_ext)
            begin
                status_next = ST_BAD_INDEX;
            end
            else if (!inuse_q)
            begin
                status_next = ST_NOT_IN_USE;
            end
            else
            begin
                inuse_we    = b_fire;
                inuse_wdata = 1'b0;
                if (depth_reg == CW'(SLOT_COUNT))
                begin
                    status_next = ST_FAULT;
                end
                else
                begin
                    stk_we     = b_fire;
                    depth_next = depth_reg + CW'(1);
                end
            end
        end

        if (!b_fire)
        begin
            depth_next = depth_reg;
            nun_next   = nun_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
            depth_reg   <= '0;
            nun_reg     <= '0;
        end
        else
        begin
            if (s_fire)
            begin
                b_valid_reg <= 1'b1;
            end
            else if (b_fire)
            begin
                b_valid_reg <= 1'b0;
            end

            if (b_fire)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end

            depth_reg <= depth_next;
            nun_reg   <= nun_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            b_op_reg  <= s_tuser;
            b_idx_reg <= s_tdata[IDX_W-1:0];
        end
        if (b_fire)
        begin
            m_status_reg <= status_next;
            m_slot_reg   <= granted_next;
        end
    end

    // in-use memory with write-through forwarding to the registered read
    always_ff @(posedge clk)
    begin
        if (inuse_we)
        begin
            inuse_mem[inuse_waddr] <= inuse_wdata;
        end
        inuse_rd_reg      <= inuse_mem[inuse_raddr];
        inuse_fwd_hit_reg <= inuse_we && (inuse_waddr == inuse_raddr);
        inuse_fwd_val_reg <= inuse_wdata;
    end

    // a push always lands on the address read back as the new top
    always_ff @(posedge clk)
    begin
        if (stk_we)
        begin
            stk_mem[stk_waddr] <= stk_wdata;
        end
        stk_rd_reg      <= stk_mem[stk_raddr];
        stk_byp_hit_reg <= stk_we;
        stk_byp_val_reg <= stk_wdata;
    end

    `SAFS_ASSERT_ALWAYS(a_depth_within_bump, clk, rst_n, depth_reg <= nun_reg)
    `SAFS_ASSERT_ALWAYS(a_bump_bounded, clk, rst_n, nun_reg <= CW'(SLOT_COUNT))
    `SAFS_ASSERT_IMPLY(a_slot_zero_unless_ok, clk, rst_n,
        m_valid_reg && (m_status_reg != ST_OK), m_slot_reg == '0)
    `SAFS_ASSERT_NEXT(a_full_keeps_counters, clk, rst_n,
        b_fire && pool_full && (b_op_reg == OP_ALLOC),
        (nun_reg == $past(nun_reg)) && (depth_reg == $past(depth_reg)))

endmodule

[verif/tb_top.sv]
// testbench for slot_allocator_free_stack: directed and random allocate/free traffic
// checked against an in-bench model of the free stack, bump counter and in-use marks
// depends on safs_pkg and the slot_allocator_free_stack rtl
module tb_top
    import safs_pkg::*;
();

    localparam int unsigned SLOT_COUNT  = 1024;
    localparam int unsigned LONG_HOLD   = 300;
    localparam int unsigned RANDOM_ITEMS = 20;

    typedef struct packed
    {
        status_t    status;
        logic [9:0] slot;
    } slot_result_t;

    // free stack model with the queue of results still owed by the block
    class slot_pool_scoreboard;
        bit           in_use [SLOT_COUNT];
        logic [9:0]   released [SLOT_COUNT];
        int unsigned  depth;
        int unsigned  bump;
        slot_result_t awaited [$];
        int unsigned  errors;

        function new();
            foreach (in_use[i]) in_use[i] = 1'b0;
            depth  = 0;
            bump   = 0;
            errors = 0;
        endfunction

        task report_mismatch(string what);
            $display("mismatch at %0t: %s", $realtime, what);
            errors++;
        endtask

        function bit pool_exhausted();
            return (depth == 0) && (bump >= SLOT_COUNT);
        endfunction

        // a slot currently handed out, or -1 when there is none
        function int pick_used_slot();
            int unsigned start;
            int unsigned k;
            if (bump == 0)
                return -1;
            start = $urandom_range(bump - 1);
            for (k = 0; k < bump; k++)
            begin
                if (in_use[(start + k) % bump])
                    return (start + k) % bump;
            end
            return -1;
        endfunction

        function void note_request(op_t op, logic [9:0] idx);
            slot_result_t r;
            int unsigned  slot;
            r.status = ST_OK;
            r.slot   = '0;
            slot     = 0;
            if (op == OP_ALLOC)
            begin
                if (depth > 0)
                begin
                    depth--;
                    slot = released[depth];
                end
                else if (bump < SLOT_COUNT)
                begin
                    slot = bump;
                    bump++;
                end
                else
                    r.status = ST_FULL;
                if (r.status == ST_OK)
                begin
                    // pop or bump stays done even when the slot turns out to be taken
                    if (slot >= SLOT_COUNT || in_use[slot])
                        r.status = ST_FAULT;
                    else
                    begin
                        in_use[slot] = 1'b1;
                        r.slot       = slot[9:0];
                    end
                end
            end
            else
            begin
                if (idx >= bump || idx >= SLOT_COUNT)
                    r.status = ST_BAD_INDEX;
                else if (!in_use[idx])
                    r.status = ST_NOT_IN_USE;
                else
                begin
                    in_use[idx] = 1'b0;
                    if (depth >= SLOT_COUNT)
                        r.status = ST_FAULT;
                    else
                    begin
                        released[depth] = idx;
                        depth++;
                    end
                end
            end
            awaited.push_back(r);
        endfunction

        task check_result(status_t status, logic [9:0] slot);
            slot_result_t want;
            if (awaited.size() == 0)
            begin
                report_mismatch($sformatf("result status %0d slot %0d with nothing outstanding",
                                          status, slot));
                return;
            end
            want = awaited.pop_front();
            if (status !== want.status)
                report_mismatch($sformatf("status %0d, wanted %0d", status, want.status));
            if (slot !== want.slot)
                report_mismatch($sformatf("granted slot %0d, wanted %0d", slot, want.slot));
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;   // [9:0] slot_index, [15:10] zero
    logic        s_tuser;   // [0] operation
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;   // [9:0] granted_slot, [15:10] zero
    logic [2:0]  m_tuser;   // [2:0] status

    slot_pool_scoreboard sb;
    int unsigned idle_phase;
    int unsigned hold_left;
    bit          held_once;

    slot_allocator_free_stack #(.SLOT_COUNT(SLOT_COUNT)) i_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #5000000;
        $display("Verification failed");
        $finish;
    end

    function automatic int unsigned sender_idle_pct();
        case (idle_phase)
            0:       return 16;
            1:       return 69;
            default: return 0;
        endcase
    endfunction

    function automatic int unsigned receiver_idle_pct();
        case (idle_phase)
            0:       return 69;
            1:       return 16;
            default: return 0;
        endcase
    endfunction

    // receiver side; one long hold-off once the no-idle phase starts
    initial
    begin
        m_tready  = 1'b0;
        hold_left = 0;
        held_once = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!held_once && idle_phase == 2)
            begin
                hold_left = LONG_HOLD;
                held_once = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(99) >= receiver_idle_pct());
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(status_t'(m_tuser), m_tdata[9:0]);
    end

    // called at a falling edge, returns at the falling edge after the transaction
    task automatic send_request(op_t op, logic [9:0] idx);
        while ($urandom_range(99) < sender_idle_pct())
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {6'b0, idx};
        do
            @(posedge clk);
        while (!(s_tvalid && s_tready));
        sb.note_request(op, idx);
        @(negedge clk);
    endtask

    // mostly allocates and frees of live slots, some frees of arbitrary indices
    task automatic send_random_request();
        int unsigned pick;
        int          used;
        pick = $urandom_range(99);
        used = sb.pick_used_slot();
        if (pick < 45)
            send_request(OP_ALLOC, 10'($urandom));
        else if (pick < 85 && used >= 0)
            send_request(OP_FREE, used[9:0]);
        else
            send_request(OP_FREE, 10'($urandom_range(SLOT_COUNT - 1)));
    endtask

    initial
    begin
        int unsigned n;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = OP_ALLOC;
        rst_n      = 1'b0;
        idle_phase = 0;
        sb         = new();
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // nothing handed out yet, so every free is out of range
        send_request(OP_FREE, 10'd0);
        send_request(OP_FREE, 10'd1023);
        send_request(OP_ALLOC, 10'h3FF);
        send_request(OP_ALLOC, 10'd0);
        send_request(OP_ALLOC, 10'd0);
        send_request(OP_FREE, 10'd1);
        send_request(OP_FREE, 10'd1);
        send_request(OP_ALLOC, 10'd0);
        send_request(OP_FREE, 10'd2);
        send_request(OP_FREE, 10'd0);
        // last in, first out
        send_request(OP_ALLOC, 10'd0);
        send_request(OP_ALLOC, 10'd0);
        // index equal to the bump counter and beyond it
        send_request(OP_FREE, 10'd3);
        send_request(OP_FREE, 10'd5);
        send_request(OP_FREE, 10'h2AA);
        send_request(OP_FREE, 10'h155);

        for (n = 0; n < RANDOM_ITEMS; n++)
            send_random_request();

        idle_phase = 1;
        // drain the pool completely, then hit the full case
        while (!sb.pool_exhausted())
            send_request(OP_ALLOC, 10'($urandom));
        repeat (3) send_request(OP_ALLOC, 10'($urandom));
        send_request(OP_FREE, 10'd1023);
        send_request(OP_FREE, 10'd1023);
        send_request(OP_ALLOC, 10'd0);
        for (n = 0; n < RANDOM_ITEMS; n++)
            send_random_request();

        idle_phase = 2;
        for (n = 0; n < RANDOM_ITEMS; n++)
            send_random_request();
        s_tvalid <= 1'b0;

        while (sb.awaited.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (sb.errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
